FILE: rtl/smms_pkg.sv
// package: item types and default sizes for the shared-memory multi-stack push block
`default_nettype none

package smms_pkg;

   // default sizes
   localparam int NUM_STACKS_DEF    = 8;
   localparam int SEGMENT_DEPTH_DEF = 64;
   localparam int WORD_WIDTH_DEF    = 32;

   // push request item
   typedef struct packed {
      logic [2:0]  stack_index;
      logic [31:0] push_word;
   } req_type;

   // push result item
   typedef struct packed {
      logic       accepted;
      logic [8:0] write_address;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/smms_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module smms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/shared_memory_multi_stack_push_top.sv
// top level: several push-only stacks in one word memory, repacked on overflow
`default_nettype none

// Several stacks share one word memory of NUM_STACKS * SEGMENT_DEPTH words.
// Each stack starts empty at the base of its own equal segment. A push item
// names a stack and a word; the word goes to that stack's top and the result
// item reports accepted=1 and the address written. When the stack has run
// into the next stack's base, the sequencer first scans upward, then
// downward, for the nearest stack with a free slot, shifts the stored words
// in between by one place and moves the boundaries of the stacks passed
// over. When no stack has room, or the stack index is not below NUM_STACKS,
// the result is accepted=0 with write_address=0 and nothing changes.
// Timing: one item at a time; req_ready is high only while idle. A push
// with room passes the check, write and done states before rsp_valid.
// A repacking push adds a scan step for each stack examined, plus a step
// where a scan runs out of stacks, and a read and a write per moved word,
// set by the single memory port pair (read the neighbor, then write it
// back one place over), plus a last read step that closes the move. A
// finished result sits in an output register, so the next item is taken
// while it waits for rsp_ready.
// Memory contents have no reset; a downward move can shift free words too.

module shared_memory_multi_stack_push_top #(
   parameter int NUM_STACKS    = smms_pkg::NUM_STACKS_DEF,
   parameter int SEGMENT_DEPTH = smms_pkg::SEGMENT_DEPTH_DEF,
   parameter int WORD_WIDTH    = smms_pkg::WORD_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire smms_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      smms_pkg::rsp_type rsp_data
);

   import smms_pkg::*;

   // sizes
   localparam int TOTAL_WORDS = NUM_STACKS * SEGMENT_DEPTH;
   localparam int AW = $clog2(TOTAL_WORDS);        // memory address
   localparam int MW = $clog2(TOTAL_WORDS + 1);    // marks, may equal TOTAL_WORDS
   localparam int TW = $clog2(NUM_STACKS);         // index into top marks
   localparam int SW = $clog2(NUM_STACKS + 1);     // index into base marks
   localparam int XW = AW + 9;                     // room for the 9-bit address field

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_CHECK   = 10'b00_0000_0010,
      ST_UP_SCAN = 10'b00_0000_0100,
      ST_UP_RD   = 10'b00_0000_1000,
      ST_UP_WR   = 10'b00_0001_0000,
      ST_DN_SCAN = 10'b00_0010_0000,
      ST_DN_RD   = 10'b00_0100_0000,
      ST_DN_WR   = 10'b00_1000_0000,
      ST_WRITE   = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

   // registers
   state_type             state_ff, state_in;
   logic [TW-1:0]         s_ff, s_in;              // stack being pushed
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [SW-1:0]         j_ff, j_in;              // scan position
   logic [MW-1:0]         a_ff, a_in;              // move address
   logic [MW-1:0]         base_ff [NUM_STACKS+1];  // last entry is the top sentinel
   logic [MW-1:0]         base_in [NUM_STACKS+1];
   logic [MW-1:0]         top_ff  [NUM_STACKS];
   logic [MW-1:0]         top_in  [NUM_STACKS];
   logic                  res_ok_ff, res_ok_in;    // pending result
   logic [8:0]            res_addr_ff, res_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // memory port signals
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [WORD_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [WORD_WIDTH-1:0] ram_rdata;

   // mark reads and helpers
   logic [SW-1:0]         s_ext;
   logic [SW-1:0]         s_next;
   logic [SW-1:0]         j_dec;
   logic [MW-1:0]         top_s;
   logic [MW-1:0]         base_s1;
   logic [MW-1:0]         top_j;
   logic [MW-1:0]         base_j1;
   logic [MW-1:0]         top_d;
   logic [MW-1:0]         base_j;
   logic [MW-1:0]         a_inc;
   logic [MW-1:0]         a_dec;
   logic [XW-1:0]         top_s_ext;
   logic [TW+2:0]         idx_ext;
   logic [WORD_WIDTH+31:0] word_ext;
   logic                  shift_up;                // close an upward move
   logic                  shift_dn;                // close a downward move
   logic                  top_bump;                // the push itself

   assign s_ext     = SW'(s_ff);
   assign s_next    = s_ext + SW'(1);
   assign j_dec     = j_ff - SW'(1);
   assign top_s     = top_ff[s_ff];
   assign base_s1   = base_ff[s_next];
   assign top_j     = top_ff[j_ff[TW-1:0]];
   assign base_j1   = base_ff[j_ff + SW'(1)];
   assign top_d     = top_ff[j_dec[TW-1:0]];
   assign base_j    = base_ff[j_ff];
   assign a_inc     = a_ff + MW'(1);
   assign a_dec     = a_ff - MW'(1);
   assign top_s_ext = XW'(top_s);
   assign idx_ext   = (TW + 3)'(req_data.stack_index);
   assign word_ext  = (WORD_WIDTH + 32)'(req_data.push_word);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      word_in      = word_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      res_ok_in    = res_ok_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = a_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = a_dec[AW-1:0];
      shift_up     = 1'b0;
      shift_dn     = 1'b0;
      top_bump     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               s_in    = idx_ext[TW-1:0];
               word_in = word_ext[WORD_WIDTH-1:0];
               if (int'(req_data.stack_index) >= NUM_STACKS) begin
                  // no such stack
                  res_ok_in   = 1'b0;
                  res_addr_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (top_s < base_s1) begin
               state_in = ST_WRITE;
            end else begin
               j_in     = s_next;
               state_in = ST_UP_SCAN;
            end
         end
         ST_UP_SCAN: begin
            if (int'(j_ff) >= NUM_STACKS) begin
               j_in     = s_ext;
               state_in = ST_DN_SCAN;
            end else if (top_j < base_j1) begin
               a_in     = top_j;
               state_in = ST_UP_RD;
            end else begin
               j_in = j_ff + SW'(1);
            end
         end
         ST_UP_RD: begin
            // move words base[s+1] .. top[j]-1 up one place, from the top down
            if (a_ff > base_s1) begin
               ram_raddr = a_dec[AW-1:0];
               state_in  = ST_UP_WR;
            end else begin
               shift_up = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_UP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = a_ff[AW-1:0];
            a_in      = a_dec;
            state_in  = ST_UP_RD;
         end
         ST_DN_SCAN: begin
            if (j_ff == '0) begin
               // memory full
               res_ok_in   = 1'b0;
               res_addr_in = '0;
               state_in    = ST_DONE;
            end else if (top_d < base_j) begin
               a_in     = top_d;
               state_in = ST_DN_RD;
            end else begin
               j_in = j_dec;
            end
         end
         ST_DN_RD: begin
            // close the free slot at top[d], from the bottom up
            if (a_inc < top_s) begin
               ram_raddr = a_inc[AW-1:0];
               state_in  = ST_DN_WR;
            end else begin
               shift_dn = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_DN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = a_ff[AW-1:0];
            a_in      = a_inc;
            state_in  = ST_DN_RD;
         end
         ST_WRITE: begin
            if (int'(top_s) >= TOTAL_WORDS) begin
               res_ok_in   = 1'b0;
               res_addr_in = '0;
            end else begin
               ram_we      = 1'b1;
               ram_waddr   = top_s[AW-1:0];
               ram_wdata   = word_ff;
               top_bump    = 1'b1;
               res_ok_in   = 1'b1;
               res_addr_in = top_s_ext[8:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.accepted      = res_ok_ff;
               rsp_in.write_address = res_addr_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // boundary updates, one per stack
   always_comb begin
      for (int k = 0; k <= NUM_STACKS; k++) begin
         base_in[k] = base_ff[k];
         if (shift_up && k > int'(s_ff) && k <= int'(j_ff)) begin
            base_in[k] = base_ff[k] + MW'(1);
         end else if (shift_dn && k >= int'(j_ff) && k <= int'(s_ff)) begin
            base_in[k] = base_ff[k] - MW'(1);
         end
      end
      for (int k = 0; k < NUM_STACKS; k++) begin
         top_in[k] = top_ff[k];
         if (shift_up && k > int'(s_ff) && k <= int'(j_ff)) begin
            top_in[k] = top_ff[k] + MW'(1);
         end else if (shift_dn && k >= int'(j_ff) && k <= int'(s_ff)) begin
            top_in[k] = top_ff[k] - MW'(1);
         end else if (top_bump && k == int'(s_ff)) begin
            top_in[k] = top_ff[k] + MW'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= NUM_STACKS; k++) begin
            base_ff[k] <= MW'(k * SEGMENT_DEPTH);
         end
         for (int k = 0; k < NUM_STACKS; k++) begin
            top_ff[k] <= MW'(k * SEGMENT_DEPTH);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      word_ff     <= word_in;
      j_ff        <= j_in;
      a_ff        <= a_in;
      res_ok_ff   <= res_ok_in;
      res_addr_ff <= res_addr_in;
      rsp_ff      <= rsp_in;
   end

   // word memory
   smms_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (TOTAL_WORDS)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
